// ----- sv/bse_pkg.sv -----
// shared types, constants and helper functions of the bitmap set engine
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

    localparam int C_MAX_WORDS = 64;
    localparam int C_WORD_W    = 64;
    localparam int C_ADDR_W    = $clog2(C_MAX_WORDS);
    localparam int C_BIT_W     = $clog2(C_WORD_W);
    // count of words in use, wide enough to hold C_MAX_WORDS itself
    localparam int C_CNT_W     = $clog2(C_MAX_WORDS + 1);
    localparam int C_POP_W     = $clog2(C_WORD_W + 1);
    localparam int C_RES_W     = 13;
    localparam int C_ACT_W     = 4;
    localparam int C_CFG_W     = 7;

    localparam logic [C_CFG_W-1:0] C_WIU_RESET = C_CFG_W'(64);

    typedef enum logic [C_ACT_W-1:0] {
        ACT_SET      = 4'd0,
        ACT_CLEAR    = 4'd1,
        ACT_TEST     = 4'd2,
        ACT_CLR_ALL  = 4'd3,
        ACT_POPCNT   = 4'd4,
        ACT_NEXT     = 4'd5,
        ACT_OR       = 4'd6,
        ACT_AND      = 4'd7,
        ACT_ANDNOT   = 4'd8,
        ACT_CLR_FROM = 4'd9
    } t_action;

    // request bundle from the sequencer to the word store
    typedef struct packed {
        logic                rd_en;
        logic [C_ADDR_W-1:0] rd_addr;
        logic                wr_en;
        logic [C_ADDR_W-1:0] wr_addr;
        logic [C_WORD_W-1:0] wr_data;
        logic                clr_en;
        logic [C_CNT_W-1:0]  clr_lo;
        logic [C_CNT_W-1:0]  clr_hi;
    } t_store_req;

    function automatic logic [C_POP_W-1:0] f_popcount(input logic [C_WORD_W-1:0] x);
        return C_POP_W'($countones(x));
    endfunction

    // position of the lowest set bit, zero for an all-zero word
    function automatic logic [C_BIT_W-1:0] f_lowest_one(input logic [C_WORD_W-1:0] x);
        logic [C_BIT_W-1:0] idx;
        idx = '0;
        for (int i = C_WORD_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = C_BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bitmap_set_engine.sv -----
// top level of the bitmap set engine: sequencer, output register and word store
`timescale 1ns / 1ps
`default_nettype none
// bit, word and clear actions: the word is read at the input transfer, then modified, written back
// and the result posted in S_WORD once the result slot is free; no new item is taken until then
// popcount walks the active words one per cycle
// next-set walks from the start word to the first non-zero word
// reset: synchronous, active low; clears every word through its valid bit, words_in_use to 64

module bitmap_set_engine
    import bse_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration: words in use
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [C_CFG_W-1:0]   i_cfg_wr_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [87:0]          s_axis_tdata,  // bit_index[11:0], word_index[17:12],
                                                     // operand_word[81:18], zero[87:82]
    input  wire logic [C_ACT_W-1:0]   s_axis_tuser,  // action[3:0]
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // bit_value[0], result_value[13:1],
                                                     // zero[15:14]
    output logic                      m_axis_tuser   // found[0]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORD = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [C_CFG_W-1:0]    r_words_in_use;
    logic [C_CNT_W-1:0]    cnt;

    // item held while it is worked on
    logic [C_ACT_W-1:0]    r_action, n_action;
    logic [C_ADDR_W-1:0]   r_addr, n_addr;
    logic [C_BIT_W-1:0]    r_bb, n_bb;
    logic                  r_inr, n_inr;
    logic [C_WORD_W-1:0]   r_opw, n_opw;

    // scan walk
    logic [C_CNT_W-1:0]    r_scan, n_scan;
    logic                  r_pend, n_pend;
    logic [C_ADDR_W-1:0]   r_pidx, n_pidx;
    logic [C_RES_W-1:0]    r_acc, n_acc;

    // output register
    logic                  r_out_valid;
    logic                  r_out_bit, n_out_bit;
    logic [C_RES_W-1:0]    r_out_res, n_out_res;
    logic                  r_out_fnd, n_out_fnd;

    t_store_req            store_req;
    logic [C_WORD_W-1:0]   word;
    logic                  slot_free;
    logic                  post;
    logic                  in_xfer;

    logic [11:0]           in_bidx;
    logic [C_ADDR_W-1:0]   in_widx;
    logic [C_ADDR_W-1:0]   in_addr;
    logic [C_WORD_W-1:0]   bit_mask;
    logic [C_WORD_W-1:0]   masked;
    logic                  more;
    logic                  hit;
    logic                  fin;

    // active word count saturates at the store depth
    assign cnt = (r_words_in_use > C_CFG_W'(C_MAX_WORDS)) ? C_CNT_W'(C_MAX_WORDS)
                                                          : C_CNT_W'(r_words_in_use);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // the result slot is free when empty or drained in this cycle
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign in_bidx  = s_axis_tdata[11:0];
    assign in_widx  = s_axis_tdata[17:12];
    // word actions address by word index, bit actions by the upper bits of the bit index
    assign in_addr  = ((s_axis_tuser == ACT_OR) || (s_axis_tuser == ACT_AND) ||
                       (s_axis_tuser == ACT_ANDNOT) || (s_axis_tuser == ACT_CLR_FROM))
                      ? in_widx : in_bidx[11:C_BIT_W];

    assign bit_mask = C_WORD_W'(1) << r_bb;
    assign masked   = word & ({C_WORD_W{1'b1}} << r_bb);

    // scan bookkeeping: a read is in flight when r_pend is high
    assign more = (r_scan < cnt);
    assign hit  = (r_action == ACT_NEXT) && r_pend && (word != '0);
    assign fin  = hit || (!r_pend && !more);

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_addr    = r_addr;
        n_bb      = r_bb;
        n_inr     = r_inr;
        n_opw     = r_opw;
        n_scan    = r_scan;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_acc     = r_acc;
        n_out_bit = 1'b0;
        n_out_res = '0;
        n_out_fnd = 1'b0;
        post      = 1'b0;
        store_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_action          = s_axis_tuser;
                    n_addr            = in_addr;
                    n_bb              = in_bidx[C_BIT_W-1:0];
                    n_inr             = (C_CNT_W'(in_addr) < cnt);
                    n_opw             = s_axis_tdata[81:18];
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = in_addr;
                    n_scan            = '0;
                    n_pend            = 1'b0;
                    n_acc             = '0;
                    n_state           = (s_axis_tuser == ACT_POPCNT) ? S_SCAN : S_WORD;
                end
            end

            S_WORD: begin
                // modify and write back the word read at the transfer
                store_req.wr_addr = r_addr;
                store_req.clr_hi  = cnt;
                post              = 1'b1;
                case (r_action)
                    ACT_SET: begin
                        store_req.wr_en   = r_inr;
                        store_req.wr_data = word | bit_mask;
                    end
                    ACT_CLEAR: begin
                        store_req.wr_en   = r_inr;
                        store_req.wr_data = word & ~bit_mask;
                    end
                    ACT_TEST: begin
                        n_out_bit = r_inr && word[r_bb];
                    end
                    ACT_CLR_ALL: begin
                        store_req.clr_en = 1'b1;
                        store_req.clr_lo = '0;
                    end
                    ACT_NEXT: begin
                        if (r_inr && (masked != '0)) begin
                            n_out_res = C_RES_W'({r_addr, f_lowest_one(masked)});
                            n_out_fnd = 1'b1;
                        end else if (r_inr) begin
                            // no set bit at or above the start bit: walk the words after it
                            post    = 1'b0;
                            n_scan  = C_CNT_W'(r_addr) + C_CNT_W'(1);
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    ACT_OR: begin
                        store_req.wr_en   = r_inr;
                        store_req.wr_data = word | r_opw;
                    end
                    ACT_AND: begin
                        store_req.wr_en   = r_inr;
                        store_req.wr_data = word & r_opw;
                    end
                    ACT_ANDNOT: begin
                        store_req.wr_en   = r_inr;
                        store_req.wr_data = word & ~r_opw;
                    end
                    ACT_CLR_FROM: begin
                        store_req.clr_en = 1'b1;
                        store_req.clr_lo = C_CNT_W'(r_addr);
                    end
                    default: begin
                    end
                endcase
                if (post) begin
                    if (slot_free) begin
                        n_state = S_IDLE;
                    end else begin
                        // hold until the result slot drains
                        post             = 1'b0;
                        store_req.wr_en  = 1'b0;
                        store_req.clr_en = 1'b0;
                    end
                end
            end

            S_SCAN: begin
                if (fin) begin
                    if (hit) begin
                        n_out_res = C_RES_W'({r_pidx, f_lowest_one(word)});
                        n_out_fnd = 1'b1;
                    end else if (r_action == ACT_POPCNT) begin
                        n_out_res = r_acc;
                    end
                    if (slot_free) begin
                        post    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // issue the next read while the previous word is folded in
                    store_req.rd_en   = more;
                    store_req.rd_addr = r_scan[C_ADDR_W-1:0];
                    n_scan            = r_scan + C_CNT_W'(more);
                    n_pend            = more;
                    n_pidx            = r_scan[C_ADDR_W-1:0];
                    if (r_pend && (r_action == ACT_POPCNT)) begin
                        n_acc = r_acc + C_RES_W'(f_popcount(word));
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_words_in_use <= C_WIU_RESET;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (i_cfg_wr_en) begin
                r_words_in_use <= i_cfg_wr_data;
            end
            if (post) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_addr   <= n_addr;
        r_bb     <= n_bb;
        r_inr    <= n_inr;
        r_opw    <= n_opw;
        r_scan   <= n_scan;
        r_pidx   <= n_pidx;
        r_acc    <= n_acc;
        if (post) begin
            r_out_bit <= n_out_bit;
            r_out_res <= n_out_res;
            r_out_fnd <= n_out_fnd;
        end
    end

    bse_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_word  (word)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_res, r_out_bit};
    assign m_axis_tuser  = r_out_fnd;

endmodule

`default_nettype wire

// ----- sv/bse_store.sv -----
// word store of the bitmap: registered-read memory plus per-word valid bits
`timescale 1ns / 1ps
`default_nettype none

module bse_store
    import bse_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_store_req          i_req,
    output logic [C_WORD_W-1:0]      o_word
);

    logic [C_WORD_W-1:0]    r_mem [C_MAX_WORDS];
    logic [C_MAX_WORDS-1:0] r_valid;
    logic [C_WORD_W-1:0]    r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // a word whose valid bit is low reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.clr_en) begin
                for (int i = 0; i < C_MAX_WORDS; i++) begin
                    if ((C_CNT_W'(i) >= i_req.clr_lo) && (C_CNT_W'(i) < i_req.clr_hi)) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_word = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- sv/bse_checker.sv -----
// port-level checks of the bitmap set engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bse_checker
    import bse_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // no result is pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: the input closes after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted two items in a row");

    // a test result never carries a find flag
    a_bit_vs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tuser)
        else $error("bit value and found both high");

    // a found index lies inside the bitmap
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[13] && !m_axis_tdata[0])
        else $error("found index out of range");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/tb_bitmap_set_engine.sv -----
// self-checking testbench of the bitmap set engine
`timescale 1ns / 1ps

module tb_bitmap_set_engine;
    import bse_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // slowest result: a next-set walk over every word plus the output stage
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_REPORTS = 10;
    // action codes with no function, the block must answer with all zeros
    localparam logic [C_ACT_W-1:0] ACT_UNUSED_LO = 4'd10;
    localparam logic [C_ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

    // one expected result transfer
    typedef struct packed {
        logic         found;
        logic [12:0]  result_value;
        logic         bit_value;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [C_CFG_W-1:0]   i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [87:0]          s_axis_tdata;
    logic [C_ACT_W-1:0]   s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tuser;

    // shadow copy of the word store and the words-in-use register
    logic [63:0]          bitmap_model [C_MAX_WORDS];
    logic [C_CFG_W-1:0]   words_in_use_model;

    t_result              pending_results [$];
    int                   mismatch_count;
    int                   cycle_count;
    bit                   tx_idle_on;
    bit                   rx_idle_on;
    int                   sink_holdoff;

    bitmap_set_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit: a hung handshake ends here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // register above the store size saturates
    function automatic int active_words();
        return (words_in_use_model > C_MAX_WORDS) ? C_MAX_WORDS : int'(words_in_use_model);
    endfunction

    function automatic logic [5:0] lowest_set_bit(input logic [63:0] w);
        logic [5:0] pos;
        pos = '0;
        for (int k = 63; k >= 0; k--) begin
            if (w[k]) begin
                pos = 6'(k);
            end
        end
        return pos;
    endfunction

    // applies one action to the shadow store and returns the result it gives
    function automatic t_result apply_action(input logic [C_ACT_W-1:0] act,
                                             input logic [11:0] bidx,
                                             input logic [5:0] widx,
                                             input logic [63:0] opw);
        t_result     r;
        int          active;
        int          bw;
        int          bb;
        logic [63:0] rest;
        r      = '0;
        active = active_words();
        bw     = int'(bidx[11:6]);
        bb     = int'(bidx[5:0]);
        case (act)
            ACT_SET: begin
                if (bw < active) bitmap_model[bw][bb] = 1'b1;
            end
            ACT_CLEAR: begin
                if (bw < active) bitmap_model[bw][bb] = 1'b0;
            end
            ACT_TEST: begin
                if (bw < active) r.bit_value = bitmap_model[bw][bb];
            end
            ACT_CLR_ALL: begin
                // inactive words keep their contents
                for (int i = 0; i < active; i++) bitmap_model[i] = '0;
            end
            ACT_POPCNT: begin
                for (int i = 0; i < active; i++) begin
                    r.result_value += 13'($countones(bitmap_model[i]));
                end
            end
            ACT_NEXT: begin
                // start beyond the active words finds nothing
                if (bw < active) begin
                    rest = bitmap_model[bw] >> bb;
                    if (rest != '0) begin
                        r.result_value = 13'(bidx) + 13'(lowest_set_bit(rest));
                        r.found        = 1'b1;
                    end else begin
                        for (int i = bw + 1; i < active && !r.found; i++) begin
                            if (bitmap_model[i] != '0) begin
                                r.result_value = 13'(i * 64)
                                               + 13'(lowest_set_bit(bitmap_model[i]));
                                r.found        = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_OR: begin
                if (widx < active) bitmap_model[widx] |= opw;
            end
            ACT_AND: begin
                if (widx < active) bitmap_model[widx] &= opw;
            end
            ACT_ANDNOT: begin
                if (widx < active) bitmap_model[widx] &= ~opw;
            end
            ACT_CLR_FROM: begin
                for (int i = int'(widx); i < active; i++) bitmap_model[i] = '0;
            end
            default: begin
                // unused codes leave the store alone
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.bit_value    = m_axis_tdata[0];
            got.result_value = m_axis_tdata[13:1];
            got.found        = m_axis_tuser;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result bit=%0b value=%0d found=%0b",
                                        got.bit_value, got.result_value, got.found));
            end else begin
                want = pending_results.pop_front();
                if (got.bit_value !== want.bit_value || got.result_value !== want.result_value
                    || got.found !== want.found) begin
                    note_mismatch($sformatf(
                        "expected bit=%0b value=%0d found=%0b, got bit=%0b value=%0d found=%0b",
                        want.bit_value, want.result_value, want.found,
                        got.bit_value, got.result_value, got.found));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_holdoff > 0) begin
                stall         = sink_holdoff;
                sink_holdoff  = 0;
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offers one item, waits for its transfer, then maybe idles the sender
    task automatic send_item(input logic [C_ACT_W-1:0] act, input logic [11:0] bidx,
                             input logic [5:0] widx, input logic [63:0] opw);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {6'b0, opw, widx, bidx};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_action(act, bidx, widx, opw));
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // sender pauses until every outstanding result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_words_in_use(input logic [C_CFG_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(posedge i_clk);
        words_in_use_model = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // mostly inside the active words, sometimes anywhere
    function automatic logic [11:0] pick_bit_index(input int active);
        if (active > 0 && $urandom_range(0, 99) < 85) begin
            return 12'($urandom_range(0, active * 64 - 1));
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [5:0] pick_word_index(input int active);
        if (active > 0 && $urandom_range(0, 99) < 85) begin
            return 6'($urandom_range(0, active - 1));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'(1) << $urandom_range(0, 63);
            3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // union, intersect or difference with another set of random length,
    // intersect clears the tail when the other set is shorter
    task automatic send_set_operation(input int active);
        logic [C_ACT_W-1:0] op;
        int                 other_len;
        case ($urandom_range(0, 2))
            0:       op = ACT_OR;
            1:       op = ACT_AND;
            default: op = ACT_ANDNOT;
        endcase
        other_len = $urandom_range(0, active);
        for (int w = 0; w < other_len; w++) begin
            send_item(op, 12'($urandom), 6'(w), pick_operand());
        end
        if (op == ACT_AND && other_len < active) begin
            send_item(ACT_CLR_FROM, 12'($urandom), 6'(other_len), {$urandom, $urandom});
        end
    endtask

    task automatic send_random_item();
        int                 active;
        int                 pick;
        logic [C_ACT_W-1:0] act;
        active = active_words();
        pick   = $urandom_range(0, 99);
        if (pick < 2) begin
            send_set_operation(active);
        end else begin
            if      (pick < 24) act = ACT_SET;
            else if (pick < 33) act = ACT_CLEAR;
            else if (pick < 48) act = ACT_TEST;
            else if (pick < 50) act = ACT_CLR_ALL;
            else if (pick < 57) act = ACT_POPCNT;
            else if (pick < 73) act = ACT_NEXT;
            else if (pick < 80) act = ACT_OR;
            else if (pick < 85) act = ACT_AND;
            else if (pick < 89) act = ACT_ANDNOT;
            else if (pick < 91) act = ACT_CLR_FROM;
            else                act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            send_item(act, pick_bit_index(active), pick_word_index(active), pick_operand());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every action with the reset setting of 64 words
    task automatic test_basic_actions();
        send_item(ACT_SET,  12'd0,    6'd0, '0);
        send_item(ACT_SET,  12'd4095, 6'd0, '0);
        send_item(ACT_SET,  12'd63,   6'd0, '0);
        send_item(ACT_TEST, 12'd0,    6'd0, '0);
        send_item(ACT_TEST, 12'd4095, 6'd0, '0);
        send_item(ACT_TEST, 12'd1,    6'd0, '0);
        send_item(ACT_NEXT, 12'd0,    6'd0, '0);
        send_item(ACT_NEXT, 12'd1,    6'd0, '0);
        send_item(ACT_NEXT, 12'd64,   6'd0, '0);
        send_item(ACT_POPCNT, 12'd0,  6'd0, '0);
        send_item(ACT_CLEAR, 12'd63,  6'd0, '0);
        send_item(ACT_TEST,  12'd63,  6'd0, '0);
        send_item(ACT_OR,     12'd0,  6'd5, '1);
        send_item(ACT_AND,    12'd0,  6'd5, 64'hFF00_FF00_FF00_FF00);
        send_item(ACT_ANDNOT, 12'd0,  6'd5, 64'h0F0F_0F0F_0F0F_0F0F);
        send_item(ACT_POPCNT, 12'd0,  6'd0, '0);
        // wipes the last two words, the top bit with them
        send_item(ACT_CLR_FROM, 12'd0, 6'd62, '0);
        send_item(ACT_NEXT,   12'd64, 6'd0, '0);
        // unused codes with every field bit high
        send_item(ACT_UNUSED_LO, '1, '1, '1);
        send_item(ACT_UNUSED_HI, '1, '1, '1);
        send_item(ACT_CLR_ALL, 12'd0, 6'd63, '0);
        send_item(ACT_POPCNT,  12'd0, 6'd0, '0);
        send_item(ACT_NEXT,    12'd0, 6'd0, '0);
        drain_results();
    endtask

    // indices past the active words, clear all sparing inactive words,
    // an empty map and a saturated register
    task automatic test_active_limits();
        send_item(ACT_SET, 12'd300, 6'd0, '0);
        send_item(ACT_SET, 12'd10,  6'd0, '0);
        drain_results();
        write_words_in_use(7'd2);
        send_item(ACT_TEST,  12'd300, 6'd0, '0);
        send_item(ACT_SET,   12'd200, 6'd0, '0);
        send_item(ACT_TEST,  12'd200, 6'd0, '0);
        send_item(ACT_NEXT,  12'd0,   6'd0, '0);
        send_item(ACT_CLEAR, 12'd10,  6'd0, '0);
        send_item(ACT_NEXT,  12'd0,   6'd0, '0);
        send_item(ACT_NEXT,  12'd300, 6'd0, '0);
        send_item(ACT_CLR_ALL, 12'd0, 6'd0, '0);
        send_item(ACT_OR,    12'd0,   6'd10, '1);
        send_item(ACT_CLR_FROM, 12'd0, 6'd40, '0);
        drain_results();
        write_words_in_use(7'd0);
        send_item(ACT_SET,    12'd0, 6'd0, '0);
        send_item(ACT_TEST,   12'd0, 6'd0, '0);
        send_item(ACT_POPCNT, 12'd0, 6'd0, '0);
        send_item(ACT_NEXT,   12'd0, 6'd0, '0);
        drain_results();
        // word 4 was never cleared while inactive
        write_words_in_use(7'd127);
        send_item(ACT_TEST,   12'd300, 6'd0, '0);
        send_item(ACT_POPCNT, 12'd0,   6'd0, '0);
        send_item(ACT_NEXT,   12'd128, 6'd0, '0);
        drain_results();
    endtask

    // random items under a range of settings with idling on both sides
    task automatic test_random_mix();
        logic [C_CFG_W-1:0] settings [9];
        int                 count;
        settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd40, 7'd64, 7'd100, 7'd0};
        settings[8] = 7'($urandom_range(0, 127));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (settings[p]) begin
            write_words_in_use(settings[p]);
            count = (settings[p] == 7'd0) ? 30 : 60;
            repeat (count) send_random_item();
            drain_results();
        end
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        write_words_in_use(7'd64);
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        sink_holdoff = 300;
        repeat (40) send_random_item();
        drain_results();
    endtask

    // no idling at all, items back to back
    task automatic test_full_rate();
        write_words_in_use(7'd16);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_random_item();
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        sink_holdoff   = 0;
        foreach (bitmap_model[i]) bitmap_model[i] = '0;
        words_in_use_model = C_WIU_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_actions();
        test_active_limits();
        test_random_mix();
        test_backpressure();
        test_full_rate();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/bse_pkg.sv
sv/bse_store.sv
sv/bitmap_set_engine.sv
sv/bse_checker.sv
tb/tb_bitmap_set_engine.sv
